FILE: design/rsp_packet_deframer_macros.svh
// Assertion macros shared by the deframer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RSP_PACKET_DEFRAMER_MACROS_SVH
`define RSP_PACKET_DEFRAMER_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define RPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define RPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rpd_pkg.sv
// Shared constants, codes, helper functions and control structs of the deframer.
// No dependencies; every other design module imports this package.
package rpd_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int IN_W        = 24;
    localparam int OUT_W       = 32;
    localparam int REP_W       = 8;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] ESC_MASK  = 8'h20;
    localparam logic [7:0] REP_BIAS  = 8'd3;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PAYLOAD = 3'd1;
    localparam logic [2:0] MODE_ESCAPE  = 3'd2;
    localparam logic [2:0] MODE_REPEAT  = 3'd3;
    localparam logic [2:0] MODE_SUM_HI  = 3'd4;
    localparam logic [2:0] MODE_SUM_LO  = 3'd5;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_START     = 4'd1;
    localparam logic [3:0] EV_STORED    = 4'd2;
    localparam logic [3:0] EV_OVERRUN   = 4'd3;
    localparam logic [3:0] EV_BAD_RLE   = 4'd4;
    localparam logic [3:0] EV_BAD_DIGIT = 4'd5;
    localparam logic [3:0] EV_BAD_SUM   = 4'd6;
    localparam logic [3:0] EV_ACCEPTED  = 4'd7;
    localparam logic [3:0] EV_GARBAGE   = 4'd8;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    typedef struct packed {
        logic accept;     // input transfer completes this cycle
        logic load_read;  // store read data is ready for the result
        logic latch_rep;  // capture the byte to be repeated
        logic fill_wr;    // write one repeated byte
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;    // offered item is a store read
        logic rpt_start;  // offered item starts a run-length fill
        logic fill_last;  // the current fill write is the last one
        logic out_free;   // result register can take a new result
    } dp_status_t;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'h30:8'h39]})
            v = c - 8'h30;
        else if (c inside {[8'h41:8'h46]})
            v = c - 8'h37;
        else if (c inside {[8'h61:8'h66]})
            v = c - 8'h57;
        return v[3:0];
    endfunction

endpackage

FILE: design/rpd_ctrl.sv
// Sequencer of the deframer: input handshake, store read wait and run-length fill.
// Depends on rpd_pkg; drives the datapath through dp_cmd_t.
module rpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rpd_pkg::dp_status_t status,
    output rpd_pkg::dp_cmd_t    cmd
);
    import rpd_pkg::*;

    typedef enum logic [3:0] {
        ST_ACCEPT   = 4'b0001,
        ST_READ     = 4'b0010,
        ST_RPT_LOAD = 4'b0100,
        ST_FILL     = 4'b1000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_ACCEPT) && status.out_free;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.load_read = 1'b0;
        cmd.latch_rep = 1'b0;
        cmd.fill_wr   = 1'b0;
        case (state_reg)
            ST_ACCEPT:
            begin
                cmd.accept = s_tvalid && s_tready;
                if (cmd.accept && status.is_read)
                    state_next = ST_READ;
                else if (cmd.accept && status.rpt_start)
                    state_next = ST_RPT_LOAD;
            end
            ST_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = ST_ACCEPT;
            end
            ST_RPT_LOAD:
            begin
                cmd.latch_rep = 1'b1;
                state_next    = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last)
                    state_next = ST_ACCEPT;
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCEPT;
        else
            state_reg <= state_next;
    end

endmodule

FILE: design/rpd_datapath.sv
// Datapath of the deframer: framing state, checksum, command store and result register.
// Depends on rpd_pkg; commanded by rpd_ctrl.
module rpd_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [rpd_pkg::IN_W-1:0] s_tdata,
    input  logic                     s_tuser,
    input  rpd_pkg::dp_cmd_t         cmd,
    output rpd_pkg::dp_status_t      status,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [rpd_pkg::OUT_W-1:0] m_tdata
);
    import rpd_pkg::*;

    logic [7:0]       c;
    logic [11:0]      ridx;
    logic [2:0]       mode_reg, mode_next;
    logic [AW-1:0]    fill_reg, fill_next;
    logic [7:0]       sum_reg, sum_next;
    logic [3:0]       nib_reg, nib_next;
    logic [REP_W-1:0] cnt_reg;
    logic [7:0]       rep_val_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             rd_ok_reg;
    logic [7:0]       mem_rdata_reg;
    logic [7:0]       mem [STORE_DEPTH];

    logic [3:0]       ev;
    logic [1:0]       rp;
    logic             wr_rx;
    logic [7:0]       wr_data_rx;
    logic             rpt;
    logic [REP_W-1:0] rep;
    logic             full;
    logic             rpt_over;
    logic [7:0]       want;
    logic             rx_step;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             idx_ok;

    function automatic logic [OUT_W-1:0] pack_out(input logic [1:0] r, input logic [3:0] e,
                                                  input logic [AW-1:0] len,
                                                  input logic [7:0] d, input logic [2:0] m);
        return {3'b000, m, d, 12'(len), e, r};
    endfunction

    assign c    = s_tdata[7:0];
    assign ridx = s_tdata[19:8];

    assign rep      = REP_W'(c - CH_SPACE + REP_BIAS);
    assign full     = fill_reg >= AW'(STORE_DEPTH - 1);
    assign rpt_over = ({1'b0, fill_reg} + (AW+1)'(rep)) >= (AW+1)'(STORE_DEPTH - 1);
    assign want     = {nib_reg, hex_val(c)};
    assign idx_ok   = 32'(ridx) < STORE_DEPTH;

    // One step of the framing machine for a received byte.
    always_comb
    begin
        mode_next  = mode_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        nib_next   = nib_reg;
        ev         = EV_NONE;
        rp         = REPLY_NONE;
        wr_rx      = 1'b0;
        wr_data_rx = c;
        rpt        = 1'b0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (c == CH_DOLLAR)
                begin
                    fill_next = '0;
                    sum_next  = 8'd0;
                    mode_next = MODE_PAYLOAD;
                    ev        = EV_START;
                end
                else
                    ev = EV_GARBAGE;
            end
            MODE_PAYLOAD:
            begin
                if (c == CH_RBRACE)
                begin
                    mode_next = MODE_ESCAPE;
                    sum_next  = sum_reg + c;
                end
                else if (c == CH_STAR)
                begin
                    mode_next = MODE_REPEAT;
                    sum_next  = sum_reg + c;
                end
                else if (c == CH_HASH)
                    mode_next = MODE_SUM_HI;
                else if (full)
                begin
                    mode_next = MODE_IDLE;
                    ev        = EV_OVERRUN;
                end
                else
                begin
                    wr_rx     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    sum_next  = sum_reg + c;
                    ev        = EV_STORED;
                end
            end
            MODE_ESCAPE:
            begin
                if (c == CH_HASH)
                    mode_next = MODE_SUM_HI;
                else if (full)
                begin
                    mode_next = MODE_IDLE;
                    ev        = EV_OVERRUN;
                end
                else
                begin
                    wr_rx      = 1'b1;
                    wr_data_rx = c ^ ESC_MASK;
                    fill_next  = fill_reg + 1'b1;
                    sum_next   = sum_reg + c;
                    mode_next  = MODE_PAYLOAD;
                    ev         = EV_STORED;
                end
            end
            MODE_REPEAT:
            begin
                if (c < CH_SPACE)
                begin
                    mode_next = MODE_PAYLOAD;
                    ev        = EV_BAD_RLE;
                end
                else if (rpt_over)
                begin
                    mode_next = MODE_IDLE;
                    ev        = EV_OVERRUN;
                end
                else if (fill_reg == '0)
                begin
                    mode_next = MODE_PAYLOAD;
                    ev        = EV_BAD_RLE;
                end
                else
                begin
                    // The fill itself runs afterwards, one store write per cycle.
                    rpt       = 1'b1;
                    sum_next  = sum_reg + c;
                    mode_next = MODE_PAYLOAD;
                    ev        = EV_STORED;
                end
            end
            MODE_SUM_HI:
            begin
                if (!hex_ok(c))
                begin
                    mode_next = MODE_PAYLOAD;
                    ev        = EV_BAD_DIGIT;
                end
                else
                begin
                    nib_next  = hex_val(c);
                    mode_next = MODE_SUM_LO;
                end
            end
            MODE_SUM_LO:
            begin
                if (!hex_ok(c))
                begin
                    mode_next = MODE_PAYLOAD;
                    ev        = EV_BAD_DIGIT;
                end
                else
                begin
                    if (want != sum_reg)
                    begin
                        rp = REPLY_NAK;
                        ev = EV_BAD_SUM;
                    end
                    else
                    begin
                        rp = REPLY_ACK;
                        ev = EV_ACCEPTED;
                    end
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    assign status.is_read   = s_tuser;
    assign status.rpt_start = !s_tuser && rpt;
    assign status.fill_last = cnt_reg == REP_W'(1);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign rx_step = cmd.accept && !s_tuser;
    assign rd_en   = cmd.accept && (s_tuser || rpt);
    assign rd_addr = s_tuser ? AW'(ridx) : fill_reg - 1'b1;
    assign wr_en   = (rx_step && wr_rx) || cmd.fill_wr;
    assign wr_data = cmd.fill_wr ? rep_val_reg : wr_data_rx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            fill_reg <= '0;
            sum_reg  <= 8'd0;
            nib_reg  <= 4'd0;
            cnt_reg  <= '0;
        end
        else if (rx_step)
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            nib_reg  <= nib_next;
            if (rpt)
                cnt_reg <= rep;
        end
        else if (cmd.fill_wr)
        begin
            fill_reg <= fill_reg + 1'b1;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    // Command store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[fill_reg] <= wr_data;
        if (rd_en)
        begin
            mem_rdata_reg <= mem[rd_addr];
            rd_ok_reg     <= !s_tuser || idx_ok;
        end
        if (cmd.latch_rep)
            rep_val_reg <= mem_rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((rx_step && !rpt) || cmd.load_read || (cmd.fill_wr && status.fill_last))
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_step && !rpt)
            out_data_reg <= pack_out(rp, ev, fill_next, 8'd0, mode_next);
        else if (cmd.load_read)
            out_data_reg <= pack_out(REPLY_NONE, EV_NONE, fill_reg,
                                     rd_ok_reg ? mem_rdata_reg : 8'd0, mode_reg);
        else if (cmd.fill_wr && status.fill_last)
            out_data_reg <= pack_out(REPLY_NONE, EV_STORED, fill_reg + 1'b1, 8'd0, mode_reg);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: design/rsp_packet_deframer.sv
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tdata: rx_byte, read_index; tuser: op
// m_*      out  m_tvalid/m_tready  tdata: reply, event_res, packet_length, read_data, parser_mode
//
// A received byte's result is registered on its transfer; a store read registers the store data first, then the result.
// A run-length fill latches the byte to repeat, then makes one store write per repeated byte.
// Reset clears the framing state at once; the command store is not cleared.
// A new transfer waits while a result is held and m_tready is low.
// Top level of the debugger packet deframer; depends on rpd_pkg, rpd_ctrl and rpd_datapath.
module rsp_packet_deframer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rpd_pkg::IN_W-1:0]  s_tdata,   // [7:0] rx_byte, [19:8] read_index
    input  logic                      s_tuser,   // [0] op
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [rpd_pkg::OUT_W-1:0] m_tdata    // [1:0] reply, [5:2] event_res,
                                                 // [17:6] packet_length, [25:18] read_data,
                                                 // [28:26] parser_mode
);
    import rpd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rpd_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/rpd_checker.sv
// Port-level checks of the deframer, attached to the top level by bind.
// Depends on rpd_pkg and rsp_packet_deframer_macros.svh.
`include "rsp_packet_deframer_macros.svh"

module rpd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [rpd_pkg::IN_W-1:0]  s_tdata,
    input logic                      s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rpd_pkg::OUT_W-1:0] m_tdata
);
    import rpd_pkg::*;

    // A held result keeps its value until its transfer.
    `RPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // No new input transfer while a result is stalled.
    `RPD_ASSERT_SAME(a_no_accept_stall, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

    // A reply goes out only with a checksum verdict.
    `RPD_ASSERT_SAME(a_reply_event, m_tvalid && m_tdata[1:0] != REPLY_NONE, m_tdata[5:2] == EV_BAD_SUM || m_tdata[5:2] == EV_ACCEPTED, "reply without checksum verdict")

    // Store data only appears on read results, which carry no event.
    `RPD_ASSERT_SAME(a_read_quiet, m_tvalid && m_tdata[25:18] != 8'd0, m_tdata[5:2] == EV_NONE && m_tdata[1:0] == REPLY_NONE, "read data with event")

    // A packet start leaves an empty packet in payload mode.
    `RPD_ASSERT_SAME(a_start_state, m_tvalid && m_tdata[5:2] == EV_START, m_tdata[17:6] == 12'd0 && m_tdata[28:26] == MODE_PAYLOAD, "bad state after start")

endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker (.*);

FILE: tb/sv/deframer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the packet deframer: mirrors the framing machine and the command store,
// then compares every result transfer field by field, in order.
// Depends on rpd_pkg for widths and for the mode, event and reply codes.
module deframer_checker
    import rpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_total,
    output int               pending,
    output int               written_span,
    output int               checked
);

    // Member order puts reply in the lowest bits, matching m_tdata.
    typedef struct packed {
        logic [2:0]    mode;
        logic [7:0]    rdata;
        logic [AW-1:0] length;
        logic [3:0]    event_code;
        logic [1:0]    reply;
    } frame_status_t;

    logic [7:0]    cmd_mem [STORE_DEPTH];
    logic [2:0]    pmode = MODE_IDLE;
    int            fill_idx = 0;
    logic [7:0]    run_sum = 8'd0;
    logic [3:0]    sum_hi = 4'd0;
    int            span = 0;
    int            errors = 0;
    int            n_checked = 0;
    frame_status_t awaiting_status [$];
    frame_status_t predicted;
    frame_status_t observed;

    // Returns {valid, value} for an ASCII hex digit of either case.
    function automatic logic [4:0] digit_decode(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, c[3:0]};
        else if (folded >= 8'h61 && folded <= 8'h66)
            return {1'b1, c[3:0] + 4'd9};
        else
            return 5'd0;
    endfunction

    task automatic store_byte(input logic [7:0] v);
        if (fill_idx < STORE_DEPTH)
            cmd_mem[fill_idx] = v;
        fill_idx++;
        if (fill_idx > span)
            span = fill_idx;
    endtask

    task automatic step_deframer(input logic op, input logic [7:0] b,
                                 input logic [AW-1:0] ridx, output frame_status_t st);
        logic [4:0] dig;
        int         rep;
        logic [7:0] last;
        st = '0;
        st.reply = REPLY_NONE;
        st.event_code = EV_NONE;
        if (op)
        begin
            st.rdata = cmd_mem[ridx];
        end
        else
        begin
            dig = digit_decode(b);
            case (pmode)
                MODE_IDLE:
                    if (b == CH_DOLLAR)
                    begin
                        fill_idx = 0;
                        run_sum = 8'd0;
                        pmode = MODE_PAYLOAD;
                        st.event_code = EV_START;
                    end
                    else
                        st.event_code = EV_GARBAGE;
                MODE_PAYLOAD:
                    if (b == CH_RBRACE)
                    begin
                        pmode = MODE_ESCAPE;
                        run_sum = run_sum + b;
                    end
                    else if (b == CH_STAR)
                    begin
                        pmode = MODE_REPEAT;
                        run_sum = run_sum + b;
                    end
                    else if (b == CH_HASH)
                        pmode = MODE_SUM_HI;
                    else if (fill_idx >= STORE_DEPTH - 1)
                    begin
                        pmode = MODE_IDLE;
                        st.event_code = EV_OVERRUN;
                    end
                    else
                    begin
                        store_byte(b);
                        run_sum = run_sum + b;
                        st.event_code = EV_STORED;
                    end
                MODE_ESCAPE:
                    if (b == CH_HASH)
                        pmode = MODE_SUM_HI;
                    else if (fill_idx >= STORE_DEPTH - 1)
                    begin
                        pmode = MODE_IDLE;
                        st.event_code = EV_OVERRUN;
                    end
                    else
                    begin
                        store_byte(b ^ ESC_MASK);
                        run_sum = run_sum + b;
                        pmode = MODE_PAYLOAD;
                        st.event_code = EV_STORED;
                    end
                MODE_REPEAT:
                    if (b < CH_SPACE)
                    begin
                        pmode = MODE_PAYLOAD;
                        st.event_code = EV_BAD_RLE;
                    end
                    else
                    begin
                        rep = int'(b - CH_SPACE) + int'(REP_BIAS);
                        if (fill_idx + rep >= STORE_DEPTH - 1)
                        begin
                            pmode = MODE_IDLE;
                            st.event_code = EV_OVERRUN;
                        end
                        else if (fill_idx < 1)
                        begin
                            pmode = MODE_PAYLOAD;
                            st.event_code = EV_BAD_RLE;
                        end
                        else
                        begin
                            last = cmd_mem[fill_idx - 1];
                            repeat (rep) store_byte(last);
                            run_sum = run_sum + b;
                            pmode = MODE_PAYLOAD;
                            st.event_code = EV_STORED;
                        end
                    end
                MODE_SUM_HI:
                    if (!dig[4])
                    begin
                        pmode = MODE_PAYLOAD;
                        st.event_code = EV_BAD_DIGIT;
                    end
                    else
                    begin
                        sum_hi = dig[3:0];
                        pmode = MODE_SUM_LO;
                    end
                MODE_SUM_LO:
                    if (!dig[4])
                    begin
                        pmode = MODE_PAYLOAD;
                        st.event_code = EV_BAD_DIGIT;
                    end
                    else
                    begin
                        if ({sum_hi, dig[3:0]} != run_sum)
                        begin
                            st.reply = REPLY_NAK;
                            st.event_code = EV_BAD_SUM;
                        end
                        else
                        begin
                            st.reply = REPLY_ACK;
                            st.event_code = EV_ACCEPTED;
                        end
                        pmode = MODE_IDLE;
                    end
                default:
                    pmode = MODE_IDLE;
            endcase
        end
        st.length = fill_idx[AW-1:0];
        st.mode = pmode;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // The command store survives reset, so the written span is kept.
            pmode = MODE_IDLE;
            fill_idx = 0;
            run_sum = 8'd0;
            sum_hi = 4'd0;
            awaiting_status.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                step_deframer(s_tuser, s_tdata[7:0], s_tdata[8 +: AW], predicted);
                awaiting_status.insert(awaiting_status.size(), predicted);
            end
            if (m_tvalid && m_tready)
            begin
                observed = m_tdata[$bits(frame_status_t)-1:0];
                if (awaiting_status.size() == 0)
                begin
                    $error("result transfer with no input transfer awaiting its result");
                    errors++;
                end
                else
                begin
                    predicted = awaiting_status.pop_front();
                    compare_field("reply", int'(predicted.reply), int'(observed.reply));
                    compare_field("event_res", int'(predicted.event_code),
                                  int'(observed.event_code));
                    compare_field("packet_length", int'(predicted.length),
                                  int'(observed.length));
                    compare_field("read_data", int'(predicted.rdata), int'(observed.rdata));
                    compare_field("parser_mode", int'(predicted.mode), int'(observed.mode));
                    n_checked++;
                end
            end
        end
        fail_total <= errors;
        pending <= awaiting_status.size();
        written_span <= span;
        checked <= n_checked;
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, link-byte and store-read stimulus,
// result back-pressure, hang watchdog and the verdict.
// Depends on rpd_pkg, rsp_packet_deframer and deframer_checker.
module testbench;
    import rpd_pkg::*;

    localparam int HANG_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 200;
    localparam int FULL_FILL   = STORE_DEPTH - 2;
    localparam int MAX_REP     = 226;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int         fail_total;
    int         pending;
    int         written_span;
    int         checked;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         item_count = 0;
    int         read_count = 0;
    int         frame_count = 0;
    int         seq_count = 0;
    int         full_count = 0;
    int         quiet_cycles = 0;
    int         idle_plan [4] = '{0, 75, 0, 30};
    int         stall_plan [4] = '{0, 0, 75, 30};
    logic [7:0] frame_sum = 8'd0;
    logic       stored_any = 1'b0;

    rsp_packet_deframer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deframer_checker status_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_total   (fail_total),
        .pending      (pending),
        .written_span (written_span),
        .checked      (checked)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= HANG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles.", HANG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic op, input logic [7:0] b, input logic [AW-1:0] idx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_W - 8 - AW){1'b0}}, idx, b};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic summed);
        send_item(1'b0, b, AW'($urandom_range(0, STORE_DEPTH - 1)));
        if (summed)
            frame_sum = frame_sum + b;
    endtask

    task automatic send_read(input int idx);
        send_item(1'b1, 8'($urandom_range(0, 255)), AW'(idx));
        read_count++;
    endtask

    task automatic open_frame();
        send_byte(CH_DOLLAR, 1'b0);
        frame_sum = 8'd0;
        stored_any = 1'b0;
        frame_count++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10)
            return 8'h30 + nib;
        else
            return (upper ? 8'h37 : 8'h57) + nib;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= 8'h30 && c <= 8'h39) || ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66));
        return c;
    endfunction

    // Any byte that is stored as it is inside a frame.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_RBRACE || c == CH_STAR || c == CH_HASH);
        return c;
    endfunction

    task automatic send_tail(input logic good, input logic with_hash);
        logic [7:0] sent;
        logic       upper;
        sent = good ? frame_sum : frame_sum ^ 8'($urandom_range(1, 255));
        upper = 1'($urandom_range(0, 1));
        if (with_hash)
            send_byte(CH_HASH, 1'b0);
        send_byte(hex_char(sent[7:4], upper), 1'b0);
        send_byte(hex_char(sent[3:0], upper), 1'b0);
    endtask

    task automatic directed_items();
        send_byte(8'h78, 1'b0);                              // stray byte outside a frame
        open_frame();
        send_byte(CH_STAR, 1'b1);                            // repeat with nothing stored
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(CH_RBRACE, 1'b1);
        send_byte(8'h03, 1'b1);
        send_byte(CH_STAR, 1'b1);                            // count below space is dropped
        send_byte(8'h1f, 1'b0);
        send_byte(CH_STAR, 1'b1);
        send_byte(8'h21, 1'b1);
        send_byte(CH_HASH, 1'b0);                            // bad high digit
        send_byte(8'h67, 1'b0);
        send_byte(CH_HASH, 1'b0);                            // good high, bad low digit
        send_byte(8'h41, 1'b0);
        send_byte(8'h7a, 1'b0);
        send_byte(CH_RBRACE, 1'b1);                          // '#' cancels the escape
        send_byte(CH_HASH, 1'b0);
        send_tail(1'b1, 1'b0);
        send_read(0);
        send_read(6);
        open_frame();
        send_byte(8'h61, 1'b1);
        send_tail(1'b0, 1'b1);
    endtask

    task automatic random_packet();
        int         n;
        int         pick;
        int         r;
        logic [7:0] cnt;
        open_frame();
        n = $urandom_range(0, 12);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_byte(plain_byte(), 1'b1);
                stored_any = 1'b1;
            end
            else if (pick < 78)
            begin
                cnt = 8'($urandom_range(0, 255));
                if (cnt == CH_HASH)
                    cnt = CH_RBRACE;
                send_byte(CH_RBRACE, 1'b1);
                send_byte(cnt, 1'b1);
                stored_any = 1'b1;
            end
            else if (pick < 94)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    cnt = 8'($urandom_range(0, 31));
                else if (r < 16)
                    cnt = 8'($urandom_range(32, 255));
                else
                    cnt = 8'($urandom_range(32, 45));
                send_byte(CH_STAR, 1'b1);
                send_byte(cnt, cnt >= CH_SPACE && stored_any);
            end
            else
            begin
                send_byte(CH_HASH, 1'b0);
                if ($urandom_range(0, 1))
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                              1'b0);
                send_byte(non_hex_byte(), 1'b0);
            end
        end
        pick = $urandom_range(0, 99);
        if (pick >= 10)
            send_tail(pick < 75, 1'b1);
        else if (pick >= 5)
        begin
            send_byte(CH_HASH, 1'b0);
            send_byte(non_hex_byte(), 1'b0);
        end
        // Otherwise the frame is left open and the next '$' lands in its payload.
    endtask

    // Fills the store to one below its last usable slot, then ends the frame in one of four ways.
    task automatic full_packet();
        int fill;
        int rep;
        open_frame();
        send_byte(plain_byte(), 1'b1);
        fill = 1;
        while (FULL_FILL - fill > MAX_REP)
        begin
            rep = $urandom_range(3, MAX_REP);
            send_byte(CH_STAR, 1'b1);
            send_byte(8'(rep + 29), 1'b1);
            fill += rep;
        end
        rep = FULL_FILL - fill;
        if (rep >= 3)
        begin
            send_byte(CH_STAR, 1'b1);
            send_byte(8'(rep + 29), 1'b1);
        end
        else
            repeat (rep) send_byte(plain_byte(), 1'b1);
        case (full_count % 4)
            0: send_byte(plain_byte(), 1'b0);
            1:
            begin
                send_byte(CH_RBRACE, 1'b1);
                send_byte(8'h7e, 1'b0);
            end
            2:
            begin
                send_byte(CH_STAR, 1'b1);
                send_byte(CH_SPACE, 1'b0);
            end
            default: send_tail(1'b1, 1'b1);
        endcase
        full_count++;
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (seq_count % 25 == 0)
            full_packet();
        else if (pick < 8)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 22 && written_span > 0)
            repeat ($urandom_range(1, 4)) send_read($urandom_range(0, written_span - 1));
        else
            random_packet();
        seq_count++;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            stall_pct <= stall_plan[ph];
            while (item_count < 25 + (ph + 1) * PHASE_ITEMS)
                random_sequence();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        $display("Sent %0d items: %0d store reads and %0d frames, %0d of them filled to the top.",
                 item_count, read_count, frame_count, full_count);
        $display("Checked %0d results across four sender-idle and receiver-stall mixes.",
                 checked);
        if (fail_total == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
